[rtl/avd_pkg.sv]
// Shared types, constants and tables for the ADPCM voice decoder.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package avd_pkg;

  localparam int unsigned PredW   = 16;
  localparam int unsigned IdxW    = 7;
  localparam int unsigned StepW   = 15;
  localparam int unsigned OffsetW = 25;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 22;
  localparam int unsigned StepCnt = 89;

  localparam logic signed [PredW-1:0] PRED_MAX = 16'sd32767;
  localparam logic signed [PredW-1:0] PRED_MIN = -16'sd32767;
  localparam logic [IdxW-1:0]         IDX_MAX  = 7'd88;
  localparam logic [OffsetW-1:0]      HDR_SIZE = 25'd4;

  localparam logic [CfgIdxW-1:0] CFG_LOOP_START  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_LOOP_LENGTH = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_REPEAT      = 2'd2;

  typedef enum logic {
    ACT_START  = 1'b0,
    ACT_DECODE = 1'b1
  } avd_action_e;

  typedef struct packed {
    logic [15:0] loop_start_words;
    logic [21:0] loop_length_words;
    logic        repeat_loop;
  } avd_cfg_t;

  typedef struct packed {
    avd_action_e action;
    logic [31:0] header_word;
    logic [7:0]  data_byte;
  } avd_item_t;

  typedef struct packed {
    logic signed [PredW-1:0] sample;
    logic [OffsetW-1:0]      fetch_offset;
    logic                    playing;
  } avd_result_t;

  localparam logic [StepW-1:0] STEP_TABLE [StepCnt] = '{
    15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14, 15'd16, 15'd17,
    15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31, 15'd34, 15'd37, 15'd41, 15'd45,
    15'd50, 15'd55, 15'd60, 15'd66, 15'd73, 15'd80, 15'd88, 15'd97, 15'd107, 15'd118,
    15'd130, 15'd143, 15'd157, 15'd173, 15'd190, 15'd209, 15'd230, 15'd253, 15'd279,
    15'd307, 15'd337, 15'd371, 15'd408, 15'd449, 15'd494, 15'd544, 15'd598, 15'd658,
    15'd724, 15'd796, 15'd876, 15'd963, 15'd1060, 15'd1166, 15'd1282, 15'd1411,
    15'd1552, 15'd1707, 15'd1878, 15'd2066, 15'd2272, 15'd2499, 15'd2749, 15'd3024,
    15'd3327, 15'd3660, 15'd4026, 15'd4428, 15'd4871, 15'd5358, 15'd5894, 15'd6484,
    15'd7132, 15'd7845, 15'd8630, 15'd9493, 15'd10442, 15'd11487, 15'd12635,
    15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623,
    15'd27086, 15'd29794, 15'd32767
  };

  localparam logic signed [4:0] IDX_ADJUST [8] = '{
    -5'sd1, -5'sd1, -5'sd1, -5'sd1, 5'sd2, 5'sd4, 5'sd6, 5'sd8
  };

endpackage

`default_nettype wire

[rtl/avd_intf.sv]
// Handshake interfaces for the ADPCM voice decoder channels.
// Input items, result items and configuration writes; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface avd_item_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] header_word;
  logic [7:0]  data_byte;

  modport source(output valid, action, header_word, data_byte, input ready);
  modport sink(input valid, action, header_word, data_byte, output ready);
endinterface

interface avd_result_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic [24:0]        fetch_offset;
  logic               playing;

  modport source(output valid, sample, fetch_offset, playing, input ready);
  modport sink(input valid, sample, fetch_offset, playing, output ready);
endinterface

interface avd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [21:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/avd_cfg_regs.sv]
// Configuration registers of the ADPCM voice decoder: loop point, loop length, repeat.
// Depends on avd_pkg and the avd_cfg_if interface.
`timescale 1ns / 1ps
`default_nettype none

module avd_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  avd_cfg_if.sink           cfg_i,
  output avd_pkg::avd_cfg_t cfg_o
);
  import avd_pkg::*;

  avd_cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_LOOP_START:  cfg_q.loop_start_words  <= cfg_i.data[15:0];
        CFG_LOOP_LENGTH: cfg_q.loop_length_words <= cfg_i.data;
        CFG_REPEAT:      cfg_q.repeat_loop       <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/avd_nibble.sv]
// One IMA ADPCM nibble step: table lookup, difference, saturation, index update.
// Purely combinational; depends on avd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module avd_nibble (
  input  logic signed [15:0] pred_i,
  input  logic [6:0]         idx_i,
  input  logic [3:0]         nib_i,
  output logic signed [15:0] pred_o,
  output logic [6:0]         idx_o
);
  import avd_pkg::*;

  logic [IdxW-1:0]  idx_c;
  logic [StepW-1:0] step;
  logic [15:0]      diff;
  logic signed [17:0] sum;
  logic signed [7:0]  idx_sum;

  always_comb begin
    idx_c = (idx_i > IDX_MAX) ? IDX_MAX : idx_i;
    step  = STEP_TABLE[idx_c];
    diff  = {4'b0, step[14:3]};
    if (nib_i[0]) begin
      diff = diff + {3'b0, step[14:2]};
    end
    if (nib_i[1]) begin
      diff = diff + {2'b0, step[14:1]};
    end
    if (nib_i[2]) begin
      diff = diff + {1'b0, step};
    end

    if (nib_i[3]) begin
      sum = {{2{pred_i[15]}}, pred_i} - $signed({2'b0, diff});
    end else begin
      sum = {{2{pred_i[15]}}, pred_i} + $signed({2'b0, diff});
    end
    if (sum > 18'sd32767) begin
      pred_o = PRED_MAX;
    end else if (sum < -18'sd32767) begin
      pred_o = PRED_MIN;
    end else begin
      pred_o = sum[15:0];
    end

    idx_sum = $signed({1'b0, idx_c}) + 8'(IDX_ADJUST[nib_i[2:0]]);
    if (idx_sum < 8'sd0) begin
      idx_o = '0;
    end else if (idx_sum > $signed({1'b0, IDX_MAX})) begin
      idx_o = IDX_MAX;
    end else begin
      idx_o = idx_sum[6:0];
    end
  end

endmodule

`default_nettype wire

[rtl/adpcm_voice_decoder_top.sv]
// Top level of the single-voice IMA ADPCM decoder.
// Depends on avd_pkg, the avd_intf interfaces, avd_cfg_regs and avd_nibble.
//
// Usage:
// Items arrive on item_in_i. A start item (action 0) loads the header word:
// predictor from bits 15:0, step index from bits 22:16 clamped to 88, fetch
// offset 4, and the voice begins playing. A decode item (action 1) carries the
// byte at the reported fetch offset; the low nibble is decoded first, then the
// high nibble, after which the offset advances. Every item yields exactly one
// result item on item_out_o with the sample, the next fetch offset and the
// playing flag. Loop point, loop length and repeat mode are written on cfg_wr_i
// while no item is in flight.
// A result passes through the input register and then the result register before
// it is offered. Throughput is one item per cycle while the receiver takes results,
// as the nibble update between the two registers is combinational.
// When the receiver stalls, the result register holds and the input register
// fills; input ready drops only when both are occupied. Reset clears all voice
// state and configuration, and the block is ready right after reset.
`timescale 1ns / 1ps
`default_nettype none

module adpcm_voice_decoder_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  avd_item_if.sink     item_in_i,
  avd_result_if.source item_out_o,
  avd_cfg_if.sink      cfg_wr_i
);
  import avd_pkg::*;

  avd_cfg_t    cfg;
  avd_item_t   in_q;
  logic        in_vld_q;
  avd_result_t res_q;
  logic        out_vld_q;
  logic        adv;

  logic signed [PredW-1:0] pred_q, pred_d, sav_pred_q, sav_pred_d, nib_pred;
  logic [IdxW-1:0]         idx_q, idx_d, sav_idx_q, sav_idx_d, nib_idx;
  logic [OffsetW-1:0]      off_q, off_d, loop_pt, loop_end;
  logic                    hi_q, hi_d, act_q, act_d;
  logic [3:0]              nib;
  logic [22:0]             end_words;

  avd_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_wr_i),
    .cfg_o  (cfg)
  );

  assign adv             = in_vld_q && (!out_vld_q || item_out_o.ready);
  assign item_in_i.ready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (item_in_i.ready) begin
      in_vld_q <= item_in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_in_i.ready && item_in_i.valid) begin
      in_q.action      <= avd_action_e'(item_in_i.action);
      in_q.header_word <= item_in_i.header_word;
      in_q.data_byte   <= item_in_i.data_byte;
    end
  end

  assign nib = hi_q ? in_q.data_byte[7:4] : in_q.data_byte[3:0];

  avd_nibble u_nibble (
    .pred_i (pred_q),
    .idx_i  (idx_q),
    .nib_i  (nib),
    .pred_o (nib_pred),
    .idx_o  (nib_idx)
  );

  assign loop_pt   = {7'b0, cfg.loop_start_words, 2'b0};
  assign end_words = {7'b0, cfg.loop_start_words} + {1'b0, cfg.loop_length_words};
  assign loop_end  = {end_words, 2'b0};

  always_comb begin
    pred_d     = pred_q;
    idx_d      = idx_q;
    sav_pred_d = sav_pred_q;
    sav_idx_d  = sav_idx_q;
    off_d      = off_q;
    hi_d       = hi_q;
    act_d      = act_q;
    if (in_q.action == ACT_START) begin
      pred_d = in_q.header_word[15:0];
      idx_d  = (in_q.header_word[22:16] > IDX_MAX) ? IDX_MAX : in_q.header_word[22:16];
      off_d  = HDR_SIZE;
      hi_d   = 1'b0;
      act_d  = 1'b1;
    end else if (act_q) begin
      pred_d = nib_pred;
      idx_d  = nib_idx;
      hi_d   = !hi_q;
      if (hi_q) begin
        off_d = off_q + 25'd1;
      end
      if (hi_q && (off_d == loop_pt)) begin
        sav_pred_d = nib_pred;
        sav_idx_d  = nib_idx;
      end
      if (off_d == loop_end) begin
        if (cfg.repeat_loop) begin
          off_d  = loop_pt;
          pred_d = sav_pred_d;
          idx_d  = sav_idx_d;
          hi_d   = 1'b0;
        end else begin
          act_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pred_q     <= '0;
      idx_q      <= '0;
      sav_pred_q <= '0;
      sav_idx_q  <= '0;
      off_q      <= '0;
      hi_q       <= 1'b0;
      act_q      <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (adv) begin
        pred_q     <= pred_d;
        idx_q      <= idx_d;
        sav_pred_q <= sav_pred_d;
        sav_idx_q  <= sav_idx_d;
        off_q      <= off_d;
        hi_q       <= hi_d;
        act_q      <= act_d;
        out_vld_q  <= 1'b1;
      end else if (item_out_o.ready) begin
        out_vld_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q.sample       <= pred_d;
      res_q.fetch_offset <= off_d;
      res_q.playing      <= act_d;
    end
  end

  assign item_out_o.valid        = out_vld_q;
  assign item_out_o.sample       = res_q.sample;
  assign item_out_o.fetch_offset = res_q.fetch_offset;
  assign item_out_o.playing      = res_q.playing;

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idx_q <= IDX_MAX) && (sav_idx_q <= IDX_MAX))
    else $error("step index out of range");

  a_start_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && in_q.action == ACT_START) |=>
      (out_vld_q && res_q.playing && res_q.fetch_offset == HDR_SIZE && !hi_q))
    else $error("start item did not reload the voice");

  a_stopped_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && in_q.action == ACT_DECODE && !act_q) |=>
      ($stable(pred_q) && $stable(off_q) && $stable(idx_q) && !act_q))
    else $error("stopped voice changed state");

  a_no_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !out_vld_q) |-> adv)
    else $error("pending item not advanced into empty result register");

endmodule

`default_nettype wire
